>>> design/nart_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nart_pkg;

  // Operation codes carried in in_tuser
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_CHECK  = 3'd2;
  localparam logic [2:0] KIND_GET    = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Result status codes carried in out_tuser
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [10:0] MIN_PER_HOUR = 11'd60;

  // One stored rule, 27 bits
  typedef struct packed {
    logic [7:0] slot;
    logic [7:0] code;
    logic [5:0] minute;
    logic [4:0] hour;
  } rule_t;

  // One request, unpacked from the input stream
  typedef struct packed {
    logic [2:0]  kind;
    rule_t       rule;
    logic [7:0]  idx;
    logic [10:0] now;
  } item_t;

  // Result as held by the datapath
  typedef struct packed {
    logic [1:0] status;
    rule_t      rule;
    logic [4:0] entries;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       do_add;
    logic       do_clear;
    logic       shift_start;
    logic       shift_step;
    logic       shift_end;
    logic       scan_start;
    logic       scan_step;
    logic       take_best;
    logic       get_rd;
    logic       get_cap;
    logic       st_we;
    logic [1:0] st_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       full;
    logic       idx_bad;
    logic       empty;
    logic       now_zero;
    logic       walk_done;
    logic       pend;
    logic       found;
  } sts_t;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_GETW   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> design/next_alarm_rule_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata                        tuser
// in_      in   48b rule/index/now (see port) 3b kind
// out_     out  32b rule fields, entries_used 2b status
//
// Add, clear, unused kinds and early failures go from decode straight to the done state; get
// first reads the entry. Remove shifts the rules above the index down and check walks every
// rule: the rule memory is walked one entry per cycle.
// A new request is taken once the previous one is in the output register.
// rst_n is synchronous; the rule memory is not cleared, the rule count is.
// A stalled result holds in the output register without blocking the next request.

module next_alarm_rule_table
  import nart_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // hour[4:0] minute[10:5] type[18:11] slot[26:19] entry_index[34:27]
  // now_minute[45:35] zero[47:46]
  input  wire  [47:0] in_tdata,
  // kind[2:0]
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_hour[4:0] out_minute[10:5] out_type[18:11] out_slot[26:19]
  // entries_used[31:27]
  output logic [31:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser
);

  item_t       item;
  cmd_t        cmd;
  sts_t        sts;
  res_t        res;
  logic        res_load;
  logic        out_free;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // Unpack the request
  assign item.kind        = in_tuser;
  assign item.rule.hour   = in_tdata[4:0];
  assign item.rule.minute = in_tdata[10:5];
  assign item.rule.code   = in_tdata[18:11];
  assign item.rule.slot   = in_tdata[26:19];
  assign item.idx         = in_tdata[34:27];
  assign item.now         = in_tdata[45:35];

  nart_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .res_load (res_load),
    .cmd      (cmd)
  );

  nart_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  // Output register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tdata_r <= {res.entries, res.rule.slot, res.rule.code,
                      res.rule.minute, res.rule.hour};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && res_load))
    else $error("request taken while a result is loaded");
`endif

endmodule

`default_nettype wire

>>> design/nart_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module nart_dp
  import nart_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  item_t      item,
  input  cmd_t       cmd,
  output sts_t       sts,
  output res_t       res
);

  localparam int CW   = $clog2(MAX_RULES + 1);
  localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CMPW = (CW > 8) ? CW : 8;

  // Latched request
  logic [2:0]    kind_r;
  rule_t         rule_in_r;
  logic [7:0]    idx_r;
  logic [10:0]   now_r;

  // Table control
  logic [CW-1:0] total_r;
  logic [CW-1:0] ptr_r;
  logic          pend_r;
  logic [AW-1:0] dst_r;

  // Scan and result
  rule_t         rdata_r;
  rule_t         best_r;
  logic [10:0]   best_m_r;
  logic          found_r;
  rule_t         res_rule_r;
  logic [1:0]    res_status_r;

  // Rule memory, one write and one read port
  rule_t         mem [MAX_RULES];
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rule_t         wdata;

  logic          walk_more;
  logic          step;
  logic [10:0]   rd_m;
  logic          better;

  assign walk_more = ptr_r < total_r;
  assign step      = cmd.shift_step | cmd.scan_step;

  // Memory port steering
  assign mem_re = (step & walk_more) | cmd.get_rd;
  assign raddr  = cmd.get_rd ? AW'(idx_r) : AW'(ptr_r);
  assign mem_we = cmd.do_add | (cmd.shift_step & pend_r);
  assign waddr  = cmd.do_add ? AW'(total_r) : dst_r;
  assign wdata  = cmd.do_add ? rule_in_r : rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Minute of day of the entry just read, and the pending test
  assign rd_m   = 11'(11'(rdata_r.hour) * MIN_PER_HOUR) + 11'(rdata_r.minute);
  assign better = (rd_m >= now_r) && (!found_r || (rd_m < best_m_r));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        total_r <= '0;
      end else if (cmd.do_add) begin
        total_r <= total_r + CW'(1);
      end else if (cmd.shift_end) begin
        total_r <= total_r - CW'(1);
      end
      pend_r <= step & walk_more;
    end
  end

  // Request latch, walk pointer, scan tracking and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= item.kind;
      rule_in_r    <= item.rule;
      idx_r        <= item.idx;
      now_r        <= item.now;
      res_rule_r   <= '0;
      res_status_r <= ST_OK;
    end
    if (cmd.shift_start) begin
      ptr_r <= CW'(idx_r) + CW'(1);
    end else if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (step && walk_more) begin
      ptr_r <= ptr_r + CW'(1);
    end
    // destination of a shift is one below the entry being read
    if (cmd.shift_step && walk_more) begin
      dst_r <= AW'(ptr_r - CW'(1));
    end
    if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (cmd.scan_step && pend_r && better) begin
      found_r  <= 1'b1;
      best_r   <= rdata_r;
      best_m_r <= rd_m;
    end
    if (cmd.st_we) begin
      res_status_r <= cmd.st_code;
    end
    if (cmd.take_best) begin
      res_rule_r <= found_r ? best_r : '0;
    end else if (cmd.get_cap) begin
      res_rule_r <= rdata_r;
    end
  end

  // Status toward the controller
  assign sts.kind      = kind_r;
  assign sts.full      = total_r == CW'(MAX_RULES);
  assign sts.idx_bad   = CMPW'(idx_r) >= CMPW'(total_r);
  assign sts.empty     = total_r == '0;
  assign sts.now_zero  = now_r == '0;
  assign sts.walk_done = !walk_more;
  assign sts.pend      = pend_r;
  assign sts.found     = found_r;

  assign res.status  = res_status_r;
  assign res.rule    = res_rule_r;
  assign res.entries = 5'(total_r);

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_RULES))
    else $error("rule count above table size");

  a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(mem_re))
    else $error("pending entry without a read");

  a_shift_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_step && pend_r) |-> (CW'(dst_r) < total_r))
    else $error("shift write outside the table");
`endif

endmodule

`default_nettype wire

>>> design/nart_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nart_ctrl
  import nart_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  input  wire   out_free,
  input  sts_t  sts,
  output logic  in_ready,
  output logic  res_load,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing of each request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.kind)
          KIND_ADD: begin
            if (sts.full) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.do_add = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (sts.idx_bad) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_NOTFOUND;
            end else begin
              cmd.shift_start = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
          KIND_CHECK: begin
            if (sts.empty || sts.now_zero) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_NONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          KIND_GET: begin
            if (sts.idx_bad) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_NOTFOUND;
            end else begin
              cmd.get_rd = 1'b1;
              state_nxt  = S_GETW;
            end
          end
          KIND_CLEAR: begin
            cmd.do_clear = 1'b1;
          end
          default: begin
            // unused kinds report ok and change nothing
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.walk_done && !sts.pend) begin
          cmd.shift_end = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.walk_done && !sts.pend) begin
          cmd.take_best = 1'b1;
          cmd.st_we     = 1'b1;
          cmd.st_code   = sts.found ? ST_OK : ST_NONE;
          state_nxt     = S_DONE;
        end
      end
      S_GETW: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> tb/next_alarm_rule_table_tb.sv
`timescale 1ns / 1ps

module next_alarm_rule_table_tb
  import nart_pkg::*;
();

  localparam int TABLE_DEPTH = 16;
  localparam int ITEM_TARGET = 1350;
  localparam int BURST_LEN   = 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int MINUTES_PER_DAY = 1440;

  // kinds the block treats as no-ops
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  next_alarm_rule_table #(
    .MAX_RULES(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // shadow copy of the rule table
  rule_t rule_mirror [TABLE_DEPTH];
  int    mirror_total = 0;

  res_t  awaited_replies [$];
  int    sent_total = 0;
  int    error_count = 0;
  int    status_seen [4] = '{0, 0, 0, 0};

  typedef struct {
    item_t req;
    bit    fixed;
    res_t  want;
  } plan_row_t;

  plan_row_t plan [$];

  // apply one request to the shadow table, return the reply it must produce
  function automatic res_t predict_reply(input item_t it);
    res_t r;
    int   best;
    int   best_i;
    int   m;
    r = '0;
    case (it.kind)
      KIND_ADD: begin
        if (mirror_total >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          rule_mirror[mirror_total] = it.rule;
          mirror_total++;
        end
      end
      KIND_REMOVE: begin
        if (int'(it.idx) >= mirror_total) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = int'(it.idx); i + 1 < mirror_total; i++)
            rule_mirror[i] = rule_mirror[i + 1];
          mirror_total--;
          rule_mirror[mirror_total] = '0;
        end
      end
      KIND_CHECK: begin
        best = 'hFFFF;
        best_i = -1;
        if (mirror_total != 0 && it.now != 0) begin
          for (int i = 0; i < mirror_total; i++) begin
            m = int'(rule_mirror[i].hour) * 60 + int'(rule_mirror[i].minute);
            if (m >= int'(it.now) && m < best) begin
              best = m;
              best_i = i;
            end
          end
        end
        if (best_i >= 0) r.rule = rule_mirror[best_i];
        else r.status = ST_NONE;
      end
      KIND_GET: begin
        if (int'(it.idx) >= mirror_total) r.status = ST_NOTFOUND;
        else r.rule = rule_mirror[int'(it.idx)];
      end
      KIND_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) rule_mirror[i] = '0;
        mirror_total = 0;
      end
      default: ;
    endcase
    r.entries = mirror_total[4:0];
    return r;
  endfunction

  function automatic plan_row_t mk(input logic [2:0] kind, input int hour, input int minute,
                                   input int code, input int slot, input int idx, input int now,
                                   input bit fixed, input logic [1:0] st, input int used);
    plan_row_t p;
    p.req.kind = kind;
    p.req.rule.hour = 5'(hour);
    p.req.rule.minute = 6'(minute);
    p.req.rule.code = 8'(code);
    p.req.rule.slot = 8'(slot);
    p.req.idx = 8'(idx);
    p.req.now = 11'(now);
    p.fixed = fixed;
    p.want = '0;
    p.want.status = st;
    p.want.entries = 5'(used);
    return p;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // build one random request, mostly well formed against the current table
  function automatic item_t next_random_item(input int add_pct);
    item_t       it;
    logic [63:0] raw;
    int unsigned r;
    int          pick;
    raw = {$urandom, $urandom};
    it = raw[48:0];
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      it.kind = KIND_ADD;
      it.rule.hour = 5'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) :
                        $urandom_range(0, 31));
      it.rule.minute = 6'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) :
                          $urandom_range(0, 63));
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.kind = KIND_CHECK;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        it.now = '0;
      end else if (r < 25 && mirror_total > 0) begin
        // land exactly on a stored time
        pick = $urandom_range(0, mirror_total - 1);
        it.now = 11'(int'(rule_mirror[pick].hour) * 60 + int'(rule_mirror[pick].minute));
      end else if (r < 90) begin
        it.now = 11'($urandom_range(1, MINUTES_PER_DAY - 1));
      end else begin
        it.now = 11'($urandom_range(MINUTES_PER_DAY, 2047));
      end
    end else if (r < 80) begin
      it.kind = (r < 55) ? KIND_GET : KIND_REMOVE;
      if (mirror_total > 0 && $urandom_range(0, 99) < 85)
        it.idx = 8'($urandom_range(0, mirror_total - 1));
      else
        it.idx = 8'($urandom_range(mirror_total, 255));
    end else if (r < 84) begin
      it.kind = KIND_CLEAR;
    end else if (r < 88) begin
      it.kind = 3'($urandom_range(KIND_SPARE5, KIND_SPARE7));
    end
    // the rest stays fully random noise
    return it;
  endfunction

  task automatic send_request(input item_t it, input int unsigned gap, input bit fixed,
                              input res_t fixed_reply);
    res_t want;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, it.now, it.idx, it.rule};
    in_tuser <= it.kind;
    do @(posedge clk); while (!in_tready);
    want = predict_reply(it);
    awaited_replies.push_back(fixed ? fixed_reply : want);
    sent_total++;
  endtask

  // result side back-pressure
  initial begin
    int unsigned n;
    forever begin
      out_tready <= 1'b1;
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(50, 200);
      repeat (n) @(posedge clk);
      out_tready <= 1'b0;
      n = idle_len();
      if (n == 0) n = 1;
      repeat (n) @(posedge clk);
    end
  end

  // compare each accepted reply with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    rule_t got_rule;
    if (rst_n && out_tvalid && out_tready) begin
      got_rule = out_tdata[26:0];
      if (awaited_replies.size() == 0) begin
        $error("reply with nothing outstanding: status %0d data %h", out_tuser, out_tdata);
        error_count++;
      end else begin
        want = awaited_replies.pop_front();
        status_seen[out_tuser]++;
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (got_rule.hour !== want.rule.hour) begin
          $error("out_hour mismatch: expected %0d, got %0d", want.rule.hour, got_rule.hour);
          error_count++;
        end
        if (got_rule.minute !== want.rule.minute) begin
          $error("out_minute mismatch: expected %0d, got %0d", want.rule.minute,
                 got_rule.minute);
          error_count++;
        end
        if (got_rule.code !== want.rule.code) begin
          $error("out_type mismatch: expected %0d, got %0d", want.rule.code, got_rule.code);
          error_count++;
        end
        if (got_rule.slot !== want.rule.slot) begin
          $error("out_slot mismatch: expected %0d, got %0d", want.rule.slot, got_rule.slot);
          error_count++;
        end
        if (out_tdata[31:27] !== want.entries) begin
          $error("entries_used mismatch: expected %0d, got %0d", want.entries,
                 out_tdata[31:27]);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int add_pct;
    bit quiet;
    res_t none;
    none = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) rule_mirror[i] = '0;

    // directed table: kind, hour, minute, type, slot, index, now, fixed, status, entries
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0,  100, 1, ST_NONE,     0));
    plan.push_back(mk(KIND_GET,     0,  0,   0,   0,   0,    0, 1, ST_NOTFOUND, 0));
    plan.push_back(mk(KIND_REMOVE,  0,  0,   0,   0,   0,    0, 1, ST_NOTFOUND, 0));
    plan.push_back(mk(KIND_ADD,     0,  0,   0,   0,   0,    0, 1, ST_OK,       1));
    plan.push_back(mk(KIND_ADD,    23, 59, 255, 255, 255, 2047, 1, ST_OK,       2));
    plan.push_back(mk(KIND_ADD,    31, 63, 165,  90,   0,    0, 1, ST_OK,       3));
    plan.push_back(mk(KIND_GET,     0,  0,   0,   0,   2,    0, 0, ST_OK,       0));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0,    0, 1, ST_NONE,     3));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0,    1, 0, ST_OK,       0));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0, 1439, 0, ST_OK,       0));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0, 1440, 0, ST_OK,       0));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0, 2047, 1, ST_NONE,     3));
    plan.push_back(mk(KIND_ADD,    23, 59,   1,   2,   0,    0, 1, ST_OK,       4));
    // two rules share 23:59, the lower position must win
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0, 1000, 0, ST_OK,       0));
    plan.push_back(mk(KIND_GET,     0,  0,   0,   0, 255,    0, 1, ST_NOTFOUND, 4));
    plan.push_back(mk(KIND_SPARE5, 31, 63, 255, 255, 255, 2047, 1, ST_OK,       4));
    plan.push_back(mk(KIND_SPARE6, 31, 63, 255, 255,   0,    0, 1, ST_OK,       4));
    plan.push_back(mk(KIND_SPARE7,  0,  0,   0,   0, 255, 2047, 1, ST_OK,       4));
    plan.push_back(mk(KIND_REMOVE,  0,  0,   0,   0,   1,    0, 0, ST_OK,       0));
    plan.push_back(mk(KIND_REMOVE,  0,  0,   0,   0,   3,    0, 1, ST_NOTFOUND, 3));
    plan.push_back(mk(KIND_GET,     0,  0,   0,   0,   0,    0, 0, ST_OK,       0));
    plan.push_back(mk(KIND_REMOVE,  0,  0,   0,   0,   2,    0, 0, ST_OK,       0));
    plan.push_back(mk(KIND_CLEAR,  31, 63, 255, 255, 255, 2047, 1, ST_OK,       0));
    plan.push_back(mk(KIND_CHECK,   0,  0,   0,   0,   0,    1, 1, ST_NONE,     0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_request(plan[i].req, idle_len(), plan[i].fixed, plan[i].want);

    // random bursts, each with its own add bias so the table fills and drains
    while (sent_total < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: add_pct = 20;
        1: add_pct = 45;
        default: add_pct = 75;
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < BURST_LEN; k++)
        send_request(next_random_item(add_pct), quiet ? 0 : idle_len(), 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d table full, %0d not found, %0d none pending",
             sent_total, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOTFOUND],
             status_seen[ST_NONE]);
    if (error_count == 0) begin
      $display("next_alarm_rule_table regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("next_alarm_rule_table regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d replies outstanding", awaited_replies.size());
    $display("next_alarm_rule_table regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/nart_pkg.sv
design/nart_dp.sv
design/nart_ctrl.sv
design/next_alarm_rule_table.sv
tb/next_alarm_rule_table_tb.sv
